[design/rns_pkg.sv]
// Package for the recurrent network step core: payload structs, action and
// transfer codes, and the piecewise-linear curve tables.
// Depends on nothing; used by every module of the core.
package rns_pkg;

    localparam int FRAC = 12;

    typedef enum logic [1:0] {
        ACT_WEIGHT   = 2'd0,
        ACT_BIAS     = 2'd1,
        ACT_TRANSFER = 2'd2,
        ACT_STEP     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        TF_IDENTITY = 2'd0,
        TF_SIGMOID  = 2'd1,
        TF_TANH     = 2'd2,
        TF_INVALID  = 2'd3
    } transfer_t;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         target_neuron;
        logic [5:0]         source_neuron;
        logic signed [15:0] param_value;
        logic [1:0]         transfer_code;
    } req_t;

    typedef struct packed {
        logic [5:0]         neuron_index;
        logic signed [15:0] neuron_output;
        logic               status;
        logic               last;
    } rsp_t;

    // Positive half of the curves, f(x)*4096 at x = 0, 0.25, ..., 8.
    function automatic logic [12:0] sig_pos(input logic [5:0] k);
        logic [12:0] r;
        case (k)
            6'd0: r = 13'd2048;  6'd1: r = 13'd2303;  6'd2: r = 13'd2550;
            6'd3: r = 13'd2782;  6'd4: r = 13'd2994;  6'd5: r = 13'd3184;
            6'd6: r = 13'd3349;  6'd7: r = 13'd3490;  6'd8: r = 13'd3608;
            6'd9: r = 13'd3705;  6'd10: r = 13'd3785; 6'd11: r = 13'd3850;
            6'd12: r = 13'd3902; 6'd13: r = 13'd3943; 6'd14: r = 13'd3976;
            6'd15: r = 13'd4002; 6'd16: r = 13'd4022; 6'd17: r = 13'd4038;
            6'd18: r = 13'd4051; 6'd19: r = 13'd4061; 6'd20: r = 13'd4069;
            6'd21: r = 13'd4075; 6'd22: r = 13'd4079; 6'd23: r = 13'd4083;
            6'd24: r = 13'd4086; 6'd25: r = 13'd4088; 6'd26: r = 13'd4090;
            6'd27: r = 13'd4091; 6'd28: r = 13'd4092; 6'd29: r = 13'd4093;
            6'd30: r = 13'd4094; 6'd31: r = 13'd4094;
            default: r = 13'd4095;
        endcase
        return r;
    endfunction

    function automatic logic [12:0] tanh_pos(input logic [5:0] k);
        logic [12:0] r;
        case (k)
            6'd0: r = 13'd0;     6'd1: r = 13'd1003;  6'd2: r = 13'd1893;
            6'd3: r = 13'd2602;  6'd4: r = 13'd3119;  6'd5: r = 13'd3475;
            6'd6: r = 13'd3707;  6'd7: r = 13'd3856;  6'd8: r = 13'd3949;
            6'd9: r = 13'd4006;  6'd10: r = 13'd4041; 6'd11: r = 13'd4063;
            6'd12: r = 13'd4076; 6'd13: r = 13'd4084; 6'd14: r = 13'd4089;
            6'd15: r = 13'd4091; 6'd16: r = 13'd4093; 6'd17: r = 13'd4094;
            6'd18: r = 13'd4095; 6'd19: r = 13'd4095;
            default: r = 13'd4096;
        endcase
        return r;
    endfunction

    // Breakpoint k of 0..64 over [-8, 8]; the negative half is mirrored.
    function automatic logic signed [13:0] curve_point(input logic [6:0] k,
                                                       input logic is_tanh);
        logic [5:0]  m;
        logic [12:0] p;
        if (k >= 7'd32)
            m = 6'(k - 7'd32);
        else
            m = 6'(7'd32 - k);
        p = is_tanh ? tanh_pos(m) : sig_pos(m);
        if (k >= 7'd32)
            return $signed({1'b0, p});
        else if (is_tanh)
            return -$signed({1'b0, p});
        else
            return 14'sd4096 - $signed({1'b0, p});
    endfunction

endpackage

[design/rns_cell.sv]
// One cell of the accumulation chain: holds one neuron's bias, transfer code,
// output and weight row, and a multiply-accumulate. Depends on rns_pkg.
module rns_cell #(
    parameter int NEURONS     = 16,
    parameter int VALUE_WIDTH = 16,
    parameter int IDXW        = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_weight,
    input  logic                          wr_bias,
    input  logic                          wr_code,
    input  logic [IDXW-1:0]               wr_src,
    input  logic signed [VALUE_WIDTH-1:0] wr_value,
    input  logic [1:0]                    wr_code_value,
    input  logic                          clear,       // load bias into accumulator
    input  logic                          mac,         // accumulate one product
    input  logic [IDXW-1:0]               src,         // source index this cycle
    input  logic signed [VALUE_WIDTH-1:0] src_out,     // old output circulating in
    output logic signed [VALUE_WIDTH-1:0] my_out,      // this cell's stored output
    input  logic                          load_out,
    input  logic signed [VALUE_WIDTH-1:0] new_out,
    output logic signed [63:0]            acc,
    output logic [1:0]                    code
);
    localparam logic signed [63:0] ACC_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = -64'sh4000_0000_0000_0000;

    logic signed [VALUE_WIDTH-1:0] weight_reg [NEURONS];
    logic signed [VALUE_WIDTH-1:0] bias_reg;
    logic [1:0]                    code_reg;
    logic signed [VALUE_WIDTH-1:0] out_reg;
    logic signed [63:0]            acc_reg, acc_next;
    logic signed [2*VALUE_WIDTH-1:0] prod_reg;
    logic                          prod_v_reg;
    logic signed [64:0]            sum;

    always_comb
    begin
        sum = 65'(acc_reg) + 65'(prod_reg);
        if (sum > 65'(ACC_MAX))
            acc_next = ACC_MAX;
        else if (sum < 65'(ACC_MIN))
            acc_next = ACC_MIN;
        else
            acc_next = sum[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NEURONS; i++)
                weight_reg[i] <= '0;
            bias_reg   <= '0;
            code_reg   <= rns_pkg::TF_IDENTITY;
            out_reg    <= '0;
            acc_reg    <= '0;
            prod_reg   <= '0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            if (wr_weight)
                weight_reg[wr_src] <= wr_value;
            if (wr_bias)
                bias_reg <= wr_value;
            if (wr_code)
                code_reg <= wr_code_value;
            if (load_out)
                out_reg <= new_out;
            prod_v_reg <= mac;
            if (mac)
                prod_reg <= weight_reg[src] * src_out;
            if (clear)
                acc_reg <= 64'(bias_reg) <<< rns_pkg::FRAC;
            else if (prod_v_reg)
                acc_reg <= acc_next;
        end
    end

    assign my_out = out_reg;
    assign acc    = acc_reg;
    assign code   = code_reg;
endmodule

[design/rns_curve.sv]
// Rounding, saturation and transfer function of one activity, registered.
// Depends on rns_pkg.
module rns_curve #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic signed [63:0]            acc,
    input  logic [1:0]                    code,
    output logic signed [VALUE_WIDTH-1:0] result
);
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -(64'sd1 <<< (VALUE_WIDTH - 1));

    logic signed [63:0] rnd, act;
    logic signed [VALUE_WIDTH-1:0] act_reg;
    logic [1:0]                    code_reg;
    logic signed [63:0]            y;
    logic [16:0]                   u;
    logic signed [13:0]            y0, y1;
    logic signed [25:0]            prod;
    logic                          is_tanh;

    always_comb
    begin
        rnd = (acc + 64'sd2048) >>> rns_pkg::FRAC;
        if (rnd > VMAX)
            act = VMAX;
        else if (rnd < VMIN)
            act = VMIN;
        else
            act = rnd;
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act[VALUE_WIDTH-1:0];
        code_reg <= code;
    end

    always_comb
    begin
        is_tanh = (code_reg == rns_pkg::TF_TANH);
        u       = '0;
        y0      = '0;
        y1      = '0;
        prod    = '0;
        if (64'(act_reg) < -64'sd32768)
            y = 64'(rns_pkg::curve_point(7'd0, is_tanh));
        else if (64'(act_reg) >= 64'sd32768)
            y = 64'(rns_pkg::curve_point(7'd64, is_tanh));
        else
        begin
            u    = 17'(64'(act_reg) + 64'sd32768);
            y0   = rns_pkg::curve_point({1'b0, u[15:10]}, is_tanh);
            y1   = rns_pkg::curve_point(7'({1'b0, u[15:10]} + 7'd1), is_tanh);
            prod = 26'(y1 - y0) * $signed({16'd0, u[9:0]});
            y    = 64'(y0) + (64'(prod + 26'sd512) >>> 10);
        end
        if (y > VMAX)
            y = VMAX;
        else if (y < VMIN)
            y = VMIN;
        if (code_reg == rns_pkg::TF_SIGMOID || code_reg == rns_pkg::TF_TANH)
            result = y[VALUE_WIDTH-1:0];
        else
            result = act_reg;
    end
endmodule

[design/recurrent_network_step_core.sv]
// Recurrent network step core: a chain of NEURONS cells, one per neuron.
// Write requests: the response is valid in the cycle after accept; a new request is
// accepted only once that response is taken. A step accumulates over all NEURONS sources while
// the old outputs rotate one cell per cycle, then each neuron in turn passes through the
// shared transfer unit; the next request is accepted only after every result is taken.
// Reset (rst_n, asynchronous) clears weights, biases and outputs; codes become identity.
module recurrent_network_step_core #(
    parameter int NEURONS     = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rns_pkg::req_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rns_pkg::rsp_t  out_data
);
    localparam int IDXW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int CNTW = $clog2(NEURONS + 4) + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAC  = 5'b00010,
        S_WAIT = 5'b00100,
        S_ACT  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [IDXW-1:0] nidx_reg, nidx_next;
    logic            out_valid_reg, out_valid_next;
    rns_pkg::rsp_t   out_reg, out_next;

    logic signed [VALUE_WIDTH-1:0] param_sat;
    logic signed [VALUE_WIDTH-1:0] cell_out [NEURONS];
    logic signed [VALUE_WIDTH-1:0] ring_reg [NEURONS];
    logic signed [63:0]            cell_acc [NEURONS];
    logic [1:0]                    cell_code [NEURONS];
    logic [NEURONS-1:0]            wr_weight, wr_bias, wr_code, load_out;
    logic signed [VALUE_WIDTH-1:0] act_value;
    logic                          accept, tgt_ok, src_ok, step_start;
    logic [IDXW-1:0]               tgt, srcw;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign tgt_ok     = 32'(in_data.target_neuron) < NEURONS;
    assign src_ok     = 32'(in_data.source_neuron) < NEURONS;
    assign tgt        = in_data.target_neuron[IDXW-1:0];
    assign srcw       = in_data.source_neuron[IDXW-1:0];
    assign step_start = accept && (in_data.action == rns_pkg::ACT_STEP);

    // Incoming parameter saturated to the stored value width.
    always_comb
    begin
        if (in_data.param_value > 16'sd32767 >>> (16 - (VALUE_WIDTH < 16 ? VALUE_WIDTH : 16)))
            param_sat = VALUE_WIDTH'((32'sd1 <<< (VALUE_WIDTH - 1)) - 1);
        else if (32'(in_data.param_value) < -(32'sd1 <<< (VALUE_WIDTH - 1)))
            param_sat = VALUE_WIDTH'(-(32'sd1 <<< (VALUE_WIDTH - 1)));
        else
            param_sat = VALUE_WIDTH'(in_data.param_value);
    end

    always_comb
    begin
        for (int i = 0; i < NEURONS; i++)
        begin
            wr_weight[i] = accept && tgt_ok && src_ok && (tgt == IDXW'(i))
                           && (in_data.action == rns_pkg::ACT_WEIGHT);
            wr_bias[i]   = accept && tgt_ok && (tgt == IDXW'(i))
                           && (in_data.action == rns_pkg::ACT_BIAS);
            wr_code[i]   = accept && tgt_ok && (tgt == IDXW'(i))
                           && (in_data.action == rns_pkg::ACT_TRANSFER)
                           && (in_data.transfer_code != rns_pkg::TF_INVALID);
            load_out[i]  = (state_reg == S_OUT) && (nidx_reg == IDXW'(i))
                           && !out_valid_reg;
        end
    end

    // The old outputs are copied into the ring when a step is accepted and
    // then move one cell down the chain in every accumulation cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NEURONS; i++)
                ring_reg[i] <= '0;
        end
        else if (step_start)
        begin
            for (int i = 0; i < NEURONS; i++)
                ring_reg[i] <= cell_out[i];
        end
        else if (state_reg == S_MAC)
        begin
            for (int i = 0; i < NEURONS; i++)
                ring_reg[i] <= ring_reg[(i + 1) % NEURONS];
        end
    end

    // Cell i sees the output of neuron (i + cnt) mod NEURONS: the stored
    // outputs rotate past the chain, each cell taking its neighbour's value.
    for (genvar g = 0; g < NEURONS; g++)
    begin : g_cell
        logic [IDXW:0]   s_wide;
        logic [IDXW-1:0] s_idx;
        assign s_wide = (IDXW+1)'(g) + (IDXW+1)'(cnt_reg[IDXW-1:0]);
        assign s_idx  = (32'(s_wide) >= NEURONS) ? IDXW'(32'(s_wide) - NEURONS)
                                                 : s_wide[IDXW-1:0];
        rns_cell #(
            .NEURONS     (NEURONS),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDXW        (IDXW)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .wr_weight     (wr_weight[g]),
            .wr_bias       (wr_bias[g]),
            .wr_code       (wr_code[g]),
            .wr_src        (srcw),
            .wr_value      (param_sat),
            .wr_code_value (in_data.transfer_code),
            .clear         (step_start),
            .mac           (state_reg == S_MAC),
            .src           (s_idx),
            .src_out       (ring_reg[g]),
            .my_out        (cell_out[g]),
            .load_out      (load_out[g]),
            .new_out       (act_value),
            .acc           (cell_acc[g]),
            .code          (cell_code[g])
        );
    end

    rns_curve #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_curve (
        .clk    (clk),
        .acc    (cell_acc[nidx_reg]),
        .code   (cell_code[nidx_reg]),
        .result (act_value)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        nidx_next      = nidx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.action == rns_pkg::ACT_STEP)
                    begin
                        state_next = S_MAC;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        out_valid_next         = 1'b1;
                        out_next.neuron_index  = '0;
                        out_next.neuron_output = '0;
                        out_next.last          = 1'b1;
                        out_next.status        =
                            (in_data.action == rns_pkg::ACT_TRANSFER
                             && in_data.transfer_code == rns_pkg::TF_INVALID)
                            ? rns_pkg::STATUS_REJECTED : rns_pkg::STATUS_OK;
                    end
                end
            end
            S_MAC:
            begin
                if (32'(cnt_reg) == NEURONS - 1)
                begin
                    state_next = S_WAIT;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_WAIT:
            begin
                // Drain the product register into the accumulators.
                state_next = S_ACT;
                nidx_next  = '0;
            end
            S_ACT:
                state_next = S_OUT;   // transfer unit registers its input
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next         = 1'b1;
                    out_next.neuron_index  = 6'(nidx_reg);
                    out_next.neuron_output = 16'(act_value);
                    out_next.status        = rns_pkg::STATUS_OK;
                    out_next.last          = (32'(nidx_reg) == NEURONS - 1);
                    if (32'(nidx_reg) == NEURONS - 1)
                        state_next = S_IDLE;
                    else
                    begin
                        nidx_next  = nidx_reg + 1'b1;
                        state_next = S_ACT;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            nidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            nidx_reg      <= nidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state register not one-hot");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_last_ends_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.last && state_reg != S_IDLE)
        |-> 1'b0) else $error("last mark before step end");
    a_mac_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_WAIT) |-> $past(state_reg == S_MAC))
        else $error("wait entered without accumulation");
`endif
endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for recurrent_network_step_core: drives weight, bias,
// transfer and step requests and checks every response against a local model.
// Depends on rns_pkg and the core RTL.
module tb;

    localparam int NEURONS = 16;
    localparam int HALF_PERIOD = 6;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    rns_pkg::req_t in_data;
    logic out_valid;
    logic out_ready;
    rns_pkg::rsp_t out_data;

    recurrent_network_step_core #(.NEURONS(NEURONS), .VALUE_WIDTH(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // Network state as the core should hold it.
    longint weights [NEURONS*NEURONS];
    longint biases [NEURONS];
    rns_pkg::transfer_t codes [NEURONS];
    longint outputs [NEURONS];

    rns_pkg::req_t pending_reqs[$];
    rns_pkg::rsp_t expected_rsps[$];
    int errors = 0;
    bit quiet = 0;
    logic in_taken;
    int send_gap;
    int stall;

    task automatic queue_req(input rns_pkg::req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic add_expected(input rns_pkg::rsp_t r);
        expected_rsps.insert(expected_rsps.size(), r);
    endtask

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint floor_div(longint v, int s);
        return v >>> s;
    endfunction

    // Breakpoint k over [-8,8]; the negative half mirrors the positive one.
    function automatic longint knot(int k, bit is_tanh);
        int sig_half [33] = '{2048, 2303, 2550, 2782, 2994, 3184, 3349, 3490, 3608,
            3705, 3785, 3850, 3902, 3943, 3976, 4002, 4022, 4038, 4051, 4061, 4069,
            4075, 4079, 4083, 4086, 4088, 4090, 4091, 4092, 4093, 4094, 4094, 4095};
        int tanh_half [33] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949,
            4006, 4041, 4063, 4076, 4084, 4089, 4091, 4093, 4094, 4095, 4095, 4096,
            4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096};
        if (k >= 32) return is_tanh ? tanh_half[k-32] : sig_half[k-32];
        if (is_tanh) return -tanh_half[32-k];
        return 4096 - sig_half[32-k];
    endfunction

    function automatic longint squash(longint x, bit is_tanh);
        longint u, y0, y1;
        int seg;
        if (x < -32768) return clamp16(knot(0, is_tanh));
        if (x >= 32768) return clamp16(knot(64, is_tanh));
        u = x + 32768;
        seg = int'(u >> 10);
        y0 = knot(seg, is_tanh);
        y1 = knot(seg + 1, is_tanh);
        return clamp16(y0 + floor_div((y1 - y0) * (u & 1023) + 512, 10));
    endfunction

    function automatic longint acc_sat(longint a, longint b);
        longint r;
        longint top;
        top = (64'sd1 <<< 62) - 1;
        r = a + b;
        if (r > top) return top;
        if (r < -top - 1) return -top - 1;
        return r;
    endfunction

    // Applies one request to the network state and queues the responses it causes.
    task automatic predict_network(input rns_pkg::req_t r);
        longint act [NEURONS];
        longint acc, v;
        rns_pkg::rsp_t rsp;
        v = longint'(r.param_value);
        if (rns_pkg::action_t'(r.action) == rns_pkg::ACT_STEP)
        begin
            for (int i = 0; i < NEURONS; i++)
            begin
                acc = biases[i] * 4096;
                for (int j = 0; j < NEURONS; j++)
                    acc = acc_sat(acc, weights[i*NEURONS+j] * outputs[j]);
                act[i] = clamp16(floor_div(acc + 2048, rns_pkg::FRAC));
            end
            for (int i = 0; i < NEURONS; i++)
            begin
                case (codes[i])
                    rns_pkg::TF_SIGMOID: outputs[i] = squash(act[i], 1'b0);
                    rns_pkg::TF_TANH: outputs[i] = squash(act[i], 1'b1);
                    default: outputs[i] = act[i];
                endcase
                rsp.neuron_index = 6'(i);
                rsp.neuron_output = 16'(outputs[i]);
                rsp.status = rns_pkg::STATUS_OK;
                rsp.last = (i == NEURONS - 1);
                add_expected(rsp);
            end
        end
        else
        begin
            rsp = '0;
            rsp.last = 1'b1;
            rsp.status = rns_pkg::STATUS_OK;
            case (rns_pkg::action_t'(r.action))
                rns_pkg::ACT_WEIGHT:
                    if (r.target_neuron < NEURONS && r.source_neuron < NEURONS)
                        weights[r.target_neuron*NEURONS + r.source_neuron] = v;
                rns_pkg::ACT_BIAS:
                    if (r.target_neuron < NEURONS) biases[r.target_neuron] = v;
                default:
                    if (rns_pkg::transfer_t'(r.transfer_code) == rns_pkg::TF_INVALID)
                        rsp.status = rns_pkg::STATUS_REJECTED;
                    else if (r.target_neuron < NEURONS)
                        codes[r.target_neuron] = rns_pkg::transfer_t'(r.transfer_code);
            endcase
            add_expected(rsp);
        end
    endtask

    function automatic rns_pkg::req_t make_req(rns_pkg::action_t a, int tgt, int src,
                                               int val, rns_pkg::transfer_t tc);
        rns_pkg::req_t r;
        r.action = a;
        r.target_neuron = 6'(tgt);
        r.source_neuron = 6'(src);
        r.param_value = 16'(val);
        r.transfer_code = tc;
        return r;
    endfunction

    function automatic rns_pkg::req_t random_req();
        rns_pkg::req_t r;
        int sel;
        r = rns_pkg::req_t'($urandom);
        sel = $urandom_range(0, 99);
        // Mostly in-range writes with moderate values so the network does something.
        if (sel < 85)
        begin
            r.target_neuron = 6'($urandom_range(0, NEURONS - 1));
            r.source_neuron = 6'($urandom_range(0, NEURONS - 1));
            if (sel < 60) r.param_value = 16'($urandom_range(0, 8191) - 4096);
        end
        if (sel < 12) r.action = rns_pkg::ACT_STEP;
        else if (r.action == rns_pkg::ACT_STEP && sel < 70) r.action = rns_pkg::ACT_WEIGHT;
        if (r.action == rns_pkg::ACT_TRANSFER && sel < 80)
            r.transfer_code = 2'($urandom_range(0, 2));
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // The handshake completes at the rising edge; the driver acts on it at the
    // following falling edge, before any response of that request can be taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= in_valid && in_ready;
    end

    // Driver: presents requests at the falling edge, with random bursts of idling.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || in_taken)
        begin
            if (in_taken) predict_network(in_data);
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                in_data <= pending_reqs.pop_front();
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 19);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Response side back-pressure, in random bursts.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall <= 0;
        end
        else if (stall > 0)
        begin
            stall <= stall - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall <= $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: compares each accepted response with the oldest expectation.
    always @(posedge clk)
    begin
        rns_pkg::rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: expected none actual %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (out_data.neuron_index !== want.neuron_index ||
                    out_data.neuron_output !== want.neuron_output ||
                    out_data.status !== want.status || out_data.last !== want.last)
                begin
                    $display("%0t: expected %p actual %p", $time, want, out_data);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < NEURONS*NEURONS; i++) weights[i] = 0;
        for (int i = 0; i < NEURONS; i++)
        begin
            biases[i] = 0;
            codes[i] = rns_pkg::TF_IDENTITY;
            outputs[i] = 0;
        end
        rst_n = 1'b0;
        // Directed part: extremes, every action, rejected code, out-of-range indices.
        queue_req(make_req(rns_pkg::ACT_STEP, 63, 63, -1, rns_pkg::TF_INVALID));
        queue_req(make_req(rns_pkg::ACT_BIAS, 0, 0, 32767, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_BIAS, 1, 0, -32768, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_BIAS, 2, 0, 2048, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_BIAS, 63, 5, 1000, rns_pkg::TF_TANH));
        queue_req(make_req(rns_pkg::ACT_WEIGHT, 3, 0, 32767, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_WEIGHT, 4, 1, -32768, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_WEIGHT, 5, 1, 32767, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_WEIGHT, 15, 15, 4096, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_WEIGHT, 2, 63, 4096, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_WEIGHT, 40, 2, 4096, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_TRANSFER, 0, 0, 0, rns_pkg::TF_SIGMOID));
        queue_req(make_req(rns_pkg::ACT_TRANSFER, 1, 0, 0, rns_pkg::TF_TANH));
        queue_req(make_req(rns_pkg::ACT_TRANSFER, 2, 0, 0, rns_pkg::TF_INVALID));
        queue_req(make_req(rns_pkg::ACT_TRANSFER, 50, 0, 0, rns_pkg::TF_SIGMOID));
        queue_req(make_req(rns_pkg::ACT_STEP, 0, 0, 0, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_STEP, 0, 0, 0, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_TRANSFER, 3, 0, 0, rns_pkg::TF_TANH));
        queue_req(make_req(rns_pkg::ACT_TRANSFER, 4, 0, 0, rns_pkg::TF_SIGMOID));
        queue_req(make_req(rns_pkg::ACT_STEP, 0, 0, 0, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_TRANSFER, 0, 0, 0, rns_pkg::TF_IDENTITY));
        queue_req(make_req(rns_pkg::ACT_STEP, 0, 0, 0, rns_pkg::TF_IDENTITY));
        for (int n = 0; n < 260; n++) queue_req(random_req());
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // Drop idling for the tail of the run.
        wait (pending_reqs.size() < 40);
        quiet = 1;
        wait (pending_reqs.size() == 0);
        @(negedge clk);
        while (in_valid) @(negedge clk);
        @(negedge clk);
        while (expected_rsps.size() > 0) @(posedge clk);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("recurrent_network_step_core: match");
        else
            $display("recurrent_network_step_core: mismatch");
        $finish;
    end

    initial
    begin
        #(12 * 2000000);
        $display("recurrent_network_step_core: mismatch");
        $finish;
    end
endmodule

[filelist.f]
design/rns_pkg.sv
design/rns_cell.sv
design/rns_curve.sv
design/recurrent_network_step_core.sv
tb/tb.sv
